FILE: rtl/core/lsr_pkg.sv
`timescale 1ns / 1ps

package lsr_pkg;

  // Field widths
  localparam int REF_BITS  = 32;
  localparam int STEP_BITS = 16;

  // Divider widths: dividend is the difference taken one bit wider than the reference
  localparam int DIV_W = REF_BITS + 1;
  localparam int CNT_W = $clog2(DIV_W + 1);

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = ((REF_BITS + STEP_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((REF_BITS + 7) / 8) * 8;

  // Input item kinds carried in in_tuser
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  // Divider status towards the controller
  typedef struct packed {
    logic busy;
    logic done;
  } lsr_div_stat_t;

endpackage

FILE: rtl/core/lsr_div.sv
`timescale 1ns / 1ps

module lsr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lsr_pkg::DIV_W-1:0]    dividend,
  input  logic [lsr_pkg::STEP_BITS-1:0] divisor,
  output lsr_pkg::lsr_div_stat_t       stat,
  output logic [lsr_pkg::DIV_W-1:0]    quotient
);
  import lsr_pkg::*;

  logic [DIV_W-1:0]     q_r;
  logic [STEP_BITS-1:0] rem_r;
  logic [STEP_BITS-1:0] den_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 neg_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_W-1:0]     mag;
  logic [STEP_BITS:0]   shifted;
  logic [STEP_BITS:0]   trial;
  logic                 fits;

  // Take the magnitude of the signed dividend
  assign mag = dividend[DIV_W-1] ? (~dividend + DIV_W'(1)) : dividend;

  // One restoring step: bring in the next dividend bit and try the divisor
  assign shifted = {rem_r, q_r[DIV_W-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = ~trial[STEP_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
        q_r    <= mag;
        rem_r  <= '0;
        den_r  <= divisor;
        neg_r  <= dividend[DIV_W-1];
      end else if (busy_r) begin
        q_r   <= {q_r[DIV_W-2:0], fits};
        rem_r <= fits ? trial[STEP_BITS-1:0] : shifted[STEP_BITS-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restore the sign: truncation toward zero follows from dividing magnitudes
  assign quotient    = neg_r ? (~q_r + DIV_W'(1)) : q_r;
  assign stat.busy   = busy_r;
  assign stat.done   = done_r;

endmodule

FILE: rtl/core/linear_setpoint_ramp.sv
`timescale 1ns / 1ps
// Tick and zero-step command: the state moves to ST_EMIT, and out_tvalid rises once the output is free.
// Command with a nonzero step count: the state waits in ST_DIV for the serial divider,
// which resolves one quotient bit per cycle, and then moves to ST_EMIT.
// One item is worked at a time: no new item is taken until the last one is loaded for output;
// rst_n is synchronous, active low: reference, target, step count and increment clear.

module linear_setpoint_ramp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata from bit 0: target [REF_BITS], steps [STEP_BITS], zero pad
  input  logic [lsr_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser from bit 0: action
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata from bit 0: reference [REF_BITS], zero pad
  output logic [lsr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser from bit 0: done_res
  output logic [0:0]                        out_tuser
);
  import lsr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                state_r;
  logic [REF_BITS-1:0]   present_ref_r;
  logic [REF_BITS-1:0]   target_r;
  logic [STEP_BITS-1:0]  steps_left_r;
  logic [DIV_W-1:0]      increment_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_done_r;

  logic                  in_xfer;
  logic                  slot_free;
  logic                  div_start;
  logic [REF_BITS-1:0]   in_target;
  logic [STEP_BITS-1:0]  in_steps;
  logic [DIV_W-1:0]      diff;
  logic [DIV_W-1:0]      quotient;
  lsr_div_stat_t         div_stat;

  // Unpack the input transfer
  assign in_target = in_tdata[REF_BITS-1:0];
  assign in_steps  = in_tdata[REF_BITS+STEP_BITS-1:REF_BITS];
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign slot_free = ~out_valid_r | out_tready;

  // Difference at one extra bit, handed to the divider on a ramp command
  assign diff = {in_target[REF_BITS-1], in_target}
              - {present_ref_r[REF_BITS-1], present_ref_r};
  assign div_start = in_xfer & (in_tuser[0] == ACT_START) & (in_steps != '0);

  lsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff),
    .divisor  (in_steps),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Control, ramp state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      present_ref_r <= '0;
      target_r      <= '0;
      steps_left_r  <= '0;
      increment_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // Drop the output transfer unless a new result is loaded in its place
      if (out_valid_r && out_tready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_tuser[0] == ACT_START) begin
              if (in_steps == '0) begin
                // Jump straight to the target
                present_ref_r <= in_target;
                steps_left_r  <= '0;
                increment_r   <= '0;
                state_r       <= ST_EMIT;
              end else begin
                target_r     <= in_target;
                steps_left_r <= in_steps;
                state_r      <= ST_DIV;
              end
            end else begin
              // Tick: advance, snap to the target on the last step, or hold once the ramp is done
              if (steps_left_r > STEP_BITS'(1)) begin
                present_ref_r <= present_ref_r + increment_r[REF_BITS-1:0];
                steps_left_r  <= steps_left_r - STEP_BITS'(1);
              end else if (steps_left_r == STEP_BITS'(1)) begin
                present_ref_r <= target_r;
                steps_left_r  <= '0;
              end
              state_r <= ST_EMIT;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            increment_r <= quotient;
            state_r     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Hold until the output register is free
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= OUT_DATA_W'(present_ref_r);
            out_done_r  <= (steps_left_r == '0);
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_done_r;

  // The block takes one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input accepted while an item is in work");

  // A ramp command must go through the divider
  a_cmd_divides: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == ST_DIV) && div_stat.busy)
    else $error("ramp command did not start the divider");

  // Divider completion is only seen while waiting for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // Completion flag matches the remaining step count when a result is loaded
  a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && slot_free |=>
      out_tvalid && (out_tuser[0] == (steps_left_r == '0)))
    else $error("completion flag disagrees with remaining steps");

endmodule

FILE: sim/linear_setpoint_ramp_check.sv
`timescale 1ns / 1ps

module linear_setpoint_ramp_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  // in_tdata from bit 0: target [REF_BITS], steps [STEP_BITS], zero pad
  input  logic [lsr_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser from bit 0: action
  input  logic [0:0]                        in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata from bit 0: reference [REF_BITS], zero pad
  input  logic [lsr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser from bit 0: done_res
  input  logic [0:0]                        out_tuser,
  output int                                fail_count,
  output int                                pending,
  output int                                checked
);

  import lsr_pkg::*;

  typedef struct packed {
    logic [REF_BITS-1:0] reference;
    logic                done;
  } setpoint_t;

  // Ramp state as seen from outside
  logic signed [REF_BITS-1:0]  cur_ref;
  logic signed [REF_BITS-1:0]  ramp_target;
  logic        [STEP_BITS-1:0] steps_left;
  logic signed [REF_BITS:0]    step_incr;

  setpoint_t setpoint_due[$];
  int        n_fail;
  int        n_checked;
  int        n_seen;

  // Apply one accepted item to the ramp state and queue the setpoint it yields
  task automatic advance_setpoint(input logic act, input logic [REF_BITS-1:0] tgt,
                                  input logic [STEP_BITS-1:0] n);
    logic signed [REF_BITS+1:0] num;
    logic signed [REF_BITS+1:0] den;
    logic signed [REF_BITS+1:0] quo;
    setpoint_t                  sp;
    if (act == ACT_START) begin
      if (n == '0) begin
        // jump straight to the target, keep the stored target
        cur_ref    = tgt;
        steps_left = '0;
        step_incr  = '0;
      end else begin
        // difference two bits wider, signed division truncating toward zero
        num = {{2{tgt[REF_BITS-1]}}, tgt} - {{2{cur_ref[REF_BITS-1]}}, cur_ref};
        den = '0;
        den[STEP_BITS-1:0] = n;
        quo = num / den;
        ramp_target = tgt;
        steps_left  = n;
        step_incr   = quo[REF_BITS:0];
      end
    end else begin
      if (steps_left > 1) begin
        cur_ref    = cur_ref + step_incr[REF_BITS-1:0];
        steps_left = steps_left - 1'b1;
      end else if (steps_left == 1) begin
        // last step lands exactly on the target
        cur_ref    = ramp_target;
        steps_left = '0;
      end
    end
    sp.reference = cur_ref;
    sp.done      = (steps_left == '0);
    setpoint_due.push_back(sp);
  endtask

  // Compare output transfers first, then predict from input transfers
  always @(posedge clk) begin
    setpoint_t want;
    if (!rst_n) begin
      cur_ref     = '0;
      ramp_target = '0;
      steps_left  = '0;
      step_incr   = '0;
      setpoint_due.delete();
      n_fail      = 0;
      n_checked   = 0;
      n_seen      = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_seen++;
        if (setpoint_due.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch: unexpected result %0d ref=%h done=%b",
                     n_seen, out_tdata[REF_BITS-1:0], out_tuser[0]);
        end else begin
          want = setpoint_due.pop_front();
          n_checked++;
          if (out_tdata[REF_BITS-1:0] !== want.reference || out_tuser[0] !== want.done) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch: result %0d ref exp=%h act=%h done exp=%b act=%b",
                       n_seen, want.reference, out_tdata[REF_BITS-1:0],
                       want.done, out_tuser[0]);
          end
        end
      end
      if (in_tvalid && in_tready)
        advance_setpoint(in_tuser[0], in_tdata[REF_BITS-1:0],
                         in_tdata[REF_BITS +: STEP_BITS]);
    end
    fail_count <= n_fail;
    pending    <= setpoint_due.size();
    checked    <= n_checked;
  end

endmodule

FILE: sim/linear_setpoint_ramp_test.sv
`timescale 1ns / 1ps

module linear_setpoint_ramp_test;

  import lsr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int HOLD_AT = 500;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_AT = 800;

  localparam logic [REF_BITS-1:0] REF_MAX = {1'b0, {(REF_BITS-1){1'b1}}};
  localparam logic [REF_BITS-1:0] REF_MIN = {1'b1, {(REF_BITS-1){1'b0}}};

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata;
  logic [0:0]              in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic [0:0]              out_tuser;

  int fail_count;
  int pending;
  int checked;
  int cycles;
  int n_sent;
  int n_starts;
  int n_jumps;
  int n_ticks;
  logic quiet;

  linear_setpoint_ramp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  linear_setpoint_ramp_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // Clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one item, with random idle cycles ahead of it, and hold until transfer
  task automatic offer_item(input logic act, input logic [REF_BITS-1:0] tgt,
                            input logic [STEP_BITS-1:0] n);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[REF_BITS-1:0] = tgt;
    word[REF_BITS +: STEP_BITS] = n;
    while (!quiet && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    n_sent <= n_sent + 1;
    if (act == ACT_START) begin
      n_starts++;
      if (n == '0)
        n_jumps++;
    end else begin
      n_ticks++;
    end
  endtask

  // Receiver: random back-pressure, one long hold-off while the sender keeps going
  initial begin
    logic held;
    held = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && n_sent >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= 23);
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned base;
    int unsigned n_tick;
    logic [REF_BITS-1:0]  tgt;
    logic [STEP_BITS-1:0] n;
    int pick;
    n_sent    <= 0;
    n_starts  = 0;
    n_jumps   = 0;
    n_ticks   = 0;
    quiet     <= 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_TICK;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, jumps to both extremes, full-scale ramps both ways
    offer_item(ACT_TICK, '1, '1);
    offer_item(ACT_START, REF_MAX, '0);
    offer_item(ACT_START, REF_MIN, '0);
    offer_item(ACT_START, REF_MAX, 16'd1);
    offer_item(ACT_TICK, '0, '0);
    offer_item(ACT_TICK, '0, '0);
    offer_item(ACT_START, REF_MIN, 16'd3);
    repeat (3) offer_item(ACT_TICK, '0, '0);
    // Truncation toward zero for negative and positive differences
    offer_item(ACT_START, '0, '0);
    offer_item(ACT_START, -32'sd7, 16'd2);
    repeat (2) offer_item(ACT_TICK, '0, '0);
    offer_item(ACT_START, '0, 16'd2);
    repeat (2) offer_item(ACT_TICK, '0, '0);
    // Longest ramp, interrupted by a new command and then by a jump
    offer_item(ACT_START, 32'sd1000, '1);
    repeat (2) offer_item(ACT_TICK, '0, '0);
    offer_item(ACT_START, -32'sd1000, 16'd4);
    offer_item(ACT_TICK, '0, '0);
    offer_item(ACT_START, 32'sd5, '0);
    offer_item(ACT_TICK, '0, '0);

    // Random ramps: a command followed by ticks, with some noise items mixed in
    base = n_starts + n_ticks;
    while (n_starts + n_ticks - base < RANDOM_ITEMS) begin
      if (n_starts + n_ticks - base >= 200 && n_starts + n_ticks - base < 400)
        quiet <= 1'b1;
      else
        quiet <= 1'b0;
      if (n_starts + n_ticks - base >= DRAIN_AT && n_starts + n_ticks - base < DRAIN_AT + 20) begin
        // pause the sender until everything outstanding has come back
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        base = base - 20;
      end
      pick = $urandom_range(19);
      if (pick == 0) begin
        offer_item(1'($urandom_range(1)), $urandom, STEP_BITS'($urandom));
      end else begin
        case ($urandom_range(7))
          0:       tgt = REF_MAX;
          1:       tgt = REF_MIN;
          2:       tgt = '0;
          default: tgt = $urandom;
        endcase
        case ($urandom_range(19))
          0, 1:    n = '0;
          2, 3:    n = STEP_BITS'($urandom);
          4:       n = 16'd1;
          default: n = STEP_BITS'($urandom_range(24, 2));
        endcase
        offer_item(ACT_START, tgt, n);
        // mostly run the ramp out and past its end, sometimes cut it short
        if ($urandom_range(5) == 0)
          n_tick = $urandom_range(n > 3 ? n / 2 : 1);
        else
          n_tick = n + $urandom_range(3);
        if (n_tick > 40)
          n_tick = $urandom_range(40, 10);
        repeat (n_tick) offer_item(ACT_TICK, $urandom, STEP_BITS'($urandom));
      end
    end
    in_tvalid <= 1'b0;
    quiet <= 1'b0;

    // Drain, then allow for any stray result
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d ramp commands (%0d immediate jumps) and %0d ticks, %0d results checked",
             n_starts, n_jumps, n_ticks, checked);
    $display("with random back-pressure, a %0d-cycle receiver hold-off and a sender drain pause",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
